// ===== sv/lfuc_pkg.sv =====
// shared types and constants for the lfu cache with lru tie break
package lfuc_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int COUNT_BITS_DEF = 16;
	localparam int DATA_W         = 32;
	localparam int CFG_W          = 5;

	localparam logic [CFG_W-1:0]  CAP_RESET  = CFG_W'(16);
	localparam logic [DATA_W-1:0] MISS_VALUE = '1;

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	typedef struct packed {
		logic                     action;
		logic signed [DATA_W-1:0] lookup_key;
		logic signed [DATA_W-1:0] store_value;
	} in_item_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] read_value;
		logic                     evicted;
		logic signed [DATA_W-1:0] evicted_key;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_TAIL,
		ST_DECIDE,
		ST_RANK,
		ST_RANK_TAIL
	} state_t;

endpackage

// ===== sv/lfuc_ram.sv =====
// generic single-write, single-read ram with registered read data
module lfuc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/lfu_cache_lru_tiebreak.sv =====
// lfu cache with lru tie break: a get or put per transaction, one result strobe each
// a get miss or a put at capacity zero ends after the scan pass;
//   every other item runs a scan pass plus a rank pass
// one item at a time; start is taken again in the strobe cycle
// the scan walks the entry ram once, the rank pass walks the rank ram once (1r1w each)
// reset clears valid bits, entry count and the result strobe; capacity resets to 16
module lfu_cache_lru_tiebreak #(
	parameter int CAPACITY   = lfuc_pkg::CAPACITY_DEF,
	parameter int COUNT_BITS = lfuc_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  lfuc_pkg::in_item_t              request,
	output logic                            result_valid,
	output lfuc_pkg::out_item_t             result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lfuc_pkg::CFG_W-1:0]      cfg_data
);

	import lfuc_pkg::*;

	localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int HW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int EW    = 2 * DATA_W + COUNT_BITS;

	state_t state_q, state_d;

	logic [CFG_W-1:0]    capacity_q;
	logic [CAPACITY-1:0] valid_q;
	logic [CNT_W-1:0]    held_q;
	logic                res_valid_q;
	out_item_t           res_q;
	in_item_t            req_q;

	logic [IW-1:0] idx_q;
	logic [IW-1:0] idx_s1;
	logic          pend_q;

	// scan results
	logic                  found_q;
	logic [IW-1:0]         match_idx_q;
	logic [DATA_W-1:0]     match_val_q;
	logic [COUNT_BITS-1:0] match_cnt_q;
	logic [IW-1:0]         match_rank_q;
	logic                  free_found_q;
	logic [IW-1:0]         free_idx_q;
	logic                  vic_found_q;
	logic [IW-1:0]         vic_idx_q;
	logic [DATA_W-1:0]     vic_key_q;
	logic [COUNT_BITS-1:0] vic_cnt_q;
	logic [IW-1:0]         vic_rank_q;

	// rank pass control
	logic          insert_q;
	logic          evict_q;
	logic [IW-1:0] slot_q;
	logic [IW-1:0] ref_rank_q;

	// ram ports
	logic          ent_we;
	logic [IW-1:0] ent_wr_addr;
	logic [EW-1:0] ent_wr_data;
	logic [EW-1:0] ent_rd_data;
	logic          rank_we;
	logic [IW-1:0] rank_new;
	logic [IW-1:0] rank_rd_data;

	logic [DATA_W-1:0]     ent_key;
	logic [DATA_W-1:0]     ent_val;
	logic [COUNT_BITS-1:0] ent_cnt;

	logic                  is_put;
	logic [HW-1:0]         cap_ext;
	logic [HW-1:0]         cap_eff;
	logic [HW-1:0]         held_ext;
	logic                  cap_zero;
	logic                  need_evict;
	logic [IW-1:0]         slot_ins;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic                  scan_eval;
	logic                  entry_live;
	logic                  last_idx;
	logic [CAPACITY-1:0]   valid_d;
	out_item_t             res_d;

	assign ent_key = ent_rd_data[EW-1 -: DATA_W];
	assign ent_val = ent_rd_data[COUNT_BITS +: DATA_W];
	assign ent_cnt = ent_rd_data[COUNT_BITS-1:0];

	assign is_put     = (req_q.action == ACT_PUT);
	assign cap_ext    = HW'(capacity_q);
	assign cap_eff    = (cap_ext > HW'(CAPACITY)) ? HW'(CAPACITY) : cap_ext;
	assign held_ext   = HW'(held_q);
	assign cap_zero   = (cap_eff == '0);
	assign need_evict = (held_ext >= cap_eff) && vic_found_q;
	assign slot_ins   = need_evict ?
		((free_found_q && (free_idx_q < vic_idx_q)) ? free_idx_q : vic_idx_q) : free_idx_q;
	assign cnt_inc    = (&match_cnt_q) ? match_cnt_q : match_cnt_q + COUNT_BITS'(1);
	assign scan_eval  = pend_q && ((state_q == ST_SCAN) || (state_q == ST_SCAN_TAIL));
	assign entry_live = valid_q[idx_s1];
	assign last_idx   = (idx_q == IW'(CAPACITY - 1));

	assign busy         = (state_q != ST_IDLE);
	assign cfg_ready    = (state_q == ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	lfuc_ram #(
		.WIDTH(EW),
		.DEPTH(CAPACITY)
	) u_entry_ram (
		.clk    (clk),
		.wr_en  (ent_we),
		.wr_addr(ent_wr_addr),
		.wr_data(ent_wr_data),
		.rd_addr(idx_q),
		.rd_data(ent_rd_data)
	);

	lfuc_ram #(
		.WIDTH(IW),
		.DEPTH(CAPACITY)
	) u_rank_ram (
		.clk    (clk),
		.wr_en  (rank_we),
		.wr_addr(idx_s1),
		.wr_data(rank_new),
		.rd_addr(idx_q),
		.rd_data(rank_rd_data)
	);

	// new rank for the entry whose rank just came out of the ram
	always_comb begin
		if (idx_s1 == slot_q) begin
			rank_new = '0;
		end else if (insert_q) begin
			// removal shifts older ranks down, insertion shifts everything up
			rank_new = rank_rd_data +
				((evict_q && (rank_rd_data > ref_rank_q)) ? IW'(0) : IW'(1));
		end else begin
			rank_new = (rank_rd_data < ref_rank_q) ? rank_rd_data + IW'(1) : rank_rd_data;
		end
		rank_we = pend_q && entry_live &&
			((state_q == ST_RANK) || (state_q == ST_RANK_TAIL));
	end

	// valid bits after a put of a new key: victim out, new slot in
	always_comb begin
		valid_d = valid_q;
		if (need_evict) begin
			valid_d[vic_idx_q] = 1'b0;
		end
		valid_d[slot_ins] = 1'b1;
	end

	always_comb begin
		res_d = '0;
		if (!is_put) begin
			res_d.hit        = found_q;
			res_d.read_value = found_q ? match_val_q : MISS_VALUE;
		end else if (!cap_zero) begin
			if (found_q) begin
				res_d.hit = 1'b1;
			end else if (need_evict) begin
				res_d.evicted     = 1'b1;
				res_d.evicted_key = vic_key_q;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		ent_we      = 1'b0;
		ent_wr_addr = match_idx_q;
		ent_wr_data = {req_q.lookup_key, match_val_q, cnt_inc};
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_idx) begin
					state_d = ST_SCAN_TAIL;
				end
			end
			ST_SCAN_TAIL: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!is_put && !found_q) begin
					state_d = ST_IDLE;
				end else if (is_put && cap_zero) begin
					state_d = ST_IDLE;
				end else if (found_q) begin
					ent_we      = 1'b1;
					ent_wr_data = {req_q.lookup_key,
						(is_put ? req_q.store_value : match_val_q), cnt_inc};
					state_d     = ST_RANK;
				end else begin
					ent_we      = 1'b1;
					ent_wr_addr = slot_ins;
					ent_wr_data = {req_q.lookup_key, req_q.store_value, COUNT_BITS'(1)};
					state_d     = ST_RANK;
				end
			end
			ST_RANK: begin
				if (last_idx) begin
					state_d = ST_RANK_TAIL;
				end
			end
			ST_RANK_TAIL: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= CAP_RESET;
			valid_q      <= '0;
			held_q       <= '0;
			res_valid_q  <= 1'b0;
			pend_q       <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			vic_found_q  <= 1'b0;
			insert_q     <= 1'b0;
			evict_q      <= 1'b0;
		end else begin
			res_valid_q <= (state_q != ST_IDLE) && (state_d == ST_IDLE);
			pend_q      <= (state_q == ST_SCAN) || (state_q == ST_RANK);
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
			if ((state_q == ST_IDLE) && start) begin
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				vic_found_q  <= 1'b0;
			end
			if (scan_eval) begin
				if (entry_live && (ent_key == req_q.lookup_key)) begin
					found_q <= 1'b1;
				end
				if (!entry_live) begin
					free_found_q <= 1'b1;
				end
				if (entry_live) begin
					vic_found_q <= 1'b1;
				end
			end
			if (state_q == ST_DECIDE) begin
				insert_q <= !found_q;
				evict_q  <= need_evict;
				if (is_put && !cap_zero && !found_q) begin
					valid_q <= valid_d;
					if (!need_evict) begin
						held_q <= held_q + CNT_W'(1);
					end
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			idx_q <= '0;
			if (start) begin
				req_q <= request;
			end
		end else if ((state_q == ST_SCAN) || (state_q == ST_RANK)) begin
			idx_s1 <= idx_q;
			idx_q  <= idx_q + IW'(1);
		end else if (state_q == ST_DECIDE) begin
			idx_q <= '0;
		end

		if (scan_eval) begin
			if (entry_live && !found_q && (ent_key == req_q.lookup_key)) begin
				match_idx_q  <= idx_s1;
				match_val_q  <= ent_val;
				match_cnt_q  <= ent_cnt;
				match_rank_q <= rank_rd_data;
			end
			if (!entry_live && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
			// lowest count wins, equal counts go to the oldest access
			if (entry_live && (!vic_found_q || (ent_cnt < vic_cnt_q) ||
				((ent_cnt == vic_cnt_q) && (rank_rd_data > vic_rank_q)))) begin
				vic_idx_q  <= idx_s1;
				vic_key_q  <= ent_key;
				vic_cnt_q  <= ent_cnt;
				vic_rank_q <= rank_rd_data;
			end
		end

		if (state_q == ST_DECIDE) begin
			slot_q     <= found_q ? match_idx_q : slot_ins;
			ref_rank_q <= found_q ? match_rank_q : vic_rank_q;
			res_q      <= res_d;
		end
	end

endmodule

// ===== verif/tb_lfu_cache_lru_tiebreak.sv =====
// testbench for the lfu cache with lru tie break: directed table, random phases, scoreboard
`timescale 1ns / 1ps

module tb_lfu_cache_lru_tiebreak;
	import lfuc_pkg::*;

	localparam int CAP         = CAPACITY_DEF;
	// narrow use counters so that saturation is reachable in a short run
	localparam int CNT_W       = 4;
	localparam int RANK_W      = $clog2(CAP);
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 2 * CAP + 8;
	localparam int POOL_MAX    = 24;

	localparam logic signed [DATA_W-1:0] K_MIN  = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] K_MAX  = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] K_NEG1 = 32'shffff_ffff;

	localparam out_item_t GET_MISS = '{1'b0, MISS_VALUE, 1'b0, 32'sh0};
	localparam out_item_t PUT_NEW  = '0;
	localparam out_item_t PUT_HIT  = '{1'b1, 32'sh0, 1'b0, 32'sh0};

	typedef struct packed {
		logic             is_cfg;
		logic [CFG_W-1:0] cap;
		in_item_t         req;
		logic             typed;
		out_item_t        want;
	} plan_row_t;

	typedef struct packed {
		logic [CFG_W-1:0] cap;
		logic [7:0]       pool;
		logic [7:0]       items;
	} phase_t;

	localparam int PLAN_ROWS = 29;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{1'b0, 5'd0, '{ACT_GET, 32'sh0, 32'sh0}, 1'b1, GET_MISS},
		'{1'b0, 5'd0, '{ACT_GET, K_MIN, 32'sh0}, 1'b1, GET_MISS},
		'{1'b0, 5'd0, '{ACT_GET, K_MAX, K_NEG1}, 1'b1, GET_MISS},
		'{1'b0, 5'd0, '{ACT_PUT, K_MIN, K_MAX}, 1'b1, PUT_NEW},
		'{1'b0, 5'd0, '{ACT_PUT, K_MAX, K_MIN}, 1'b1, PUT_NEW},
		'{1'b0, 5'd0, '{ACT_GET, K_MIN, 32'sh0}, 1'b1, '{1'b1, K_MAX, 1'b0, 32'sh0}},
		'{1'b0, 5'd0, '{ACT_PUT, K_MIN, K_NEG1}, 1'b1, PUT_HIT},
		'{1'b0, 5'd0, '{ACT_GET, K_MIN, 32'sh0}, 1'b1, '{1'b1, K_NEG1, 1'b0, 32'sh0}},
		'{1'b0, 5'd0, '{ACT_PUT, 32'sh0, 32'sh0}, 1'b1, PUT_NEW},
		'{1'b0, 5'd0, '{ACT_GET, K_NEG1, 32'sh0}, 1'b1, GET_MISS},
		'{1'b0, 5'd0, '{ACT_GET, K_MAX, 32'sh0}, 1'b1, '{1'b1, K_MIN, 1'b0, 32'sh0}},
		// capacity dropped under the three entries held
		'{1'b1, 5'd2, '0, 1'b0, '0},
		'{1'b0, 5'd0, '{ACT_PUT, 32'sh5, 32'sh55}, 1'b0, '0},
		'{1'b0, 5'd0, '{ACT_PUT, 32'sh6, 32'sh66}, 1'b0, '0},
		'{1'b0, 5'd0, '{ACT_GET, 32'sh6, 32'sh0}, 1'b0, '0},
		'{1'b0, 5'd0, '{ACT_GET, 32'sh6, 32'sh0}, 1'b0, '0},
		'{1'b0, 5'd0, '{ACT_PUT, 32'sh7, 32'sh77}, 1'b0, '0},
		'{1'b0, 5'd0, '{ACT_GET, 32'sh0, 32'sh0}, 1'b0, '0},
		'{1'b1, 5'd1, '0, 1'b0, '0},
		'{1'b0, 5'd0, '{ACT_PUT, 32'sh8, 32'sh88}, 1'b0, '0},
		'{1'b0, 5'd0, '{ACT_PUT, 32'sh9, 32'sh99}, 1'b0, '0},
		// capacity zero: puts are no-ops, gets still see held entries
		'{1'b1, 5'd0, '0, 1'b0, '0},
		'{1'b0, 5'd0, '{ACT_PUT, 32'sha, 32'sh1}, 1'b1, PUT_NEW},
		'{1'b0, 5'd0, '{ACT_PUT, 32'sh9, 32'sh2}, 1'b1, PUT_NEW},
		'{1'b0, 5'd0, '{ACT_GET, 32'sh9, 32'sh0}, 1'b0, '0},
		// above the physical size, clamps to CAP
		'{1'b1, 5'd31, '0, 1'b0, '0},
		'{1'b0, 5'd0, '{ACT_PUT, K_MAX, 32'sh1}, 1'b0, '0},
		'{1'b0, 5'd0, '{ACT_PUT, 32'sh1234_5678, K_MIN}, 1'b0, '0},
		'{1'b0, 5'd0, '{ACT_GET, K_MAX, 32'sh0}, 1'b0, '0}
	};

	localparam int NUM_PHASES = 8;
	localparam phase_t PHASES [NUM_PHASES] = '{
		'{5'd16, 8'd20, 8'd80},
		'{5'd3,  8'd6,  8'd50},
		'{5'd1,  8'd3,  8'd40},
		'{5'd31, 8'd24, 8'd50},
		'{5'd0,  8'd8,  8'd20},
		'{5'd8,  8'd4,  8'd90},
		'{5'd17, 8'd18, 8'd50},
		'{5'd2,  8'd5,  8'd40}
	};

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	in_item_t         request;
	logic             result_valid;
	out_item_t        result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	// shadow copy of the cache
	logic                     ent_valid [CAP];
	logic signed [DATA_W-1:0] ent_key   [CAP];
	logic signed [DATA_W-1:0] ent_value [CAP];
	logic [CNT_W-1:0]         ent_count [CAP];
	logic [RANK_W-1:0]        ent_rank  [CAP];
	int                       held;
	logic [CFG_W-1:0]         cache_cap;

	out_item_t pending_results [$];
	logic signed [DATA_W-1:0] key_pool [POOL_MAX];

	int items_sent;
	int results_taken;
	int errors;
	int cfg_writes;
	int hits_seen;
	int misses_seen;
	int evictions_seen;
	int saturated_touches;
	int stall_cycles;

	lfu_cache_lru_tiebreak #(
		.CAPACITY  (CAP),
		.COUNT_BITS(CNT_W)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.result_valid(result_valid),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int find_entry(logic signed [DATA_W-1:0] key);
		for (int i = 0; i < CAP; i++)
			if (ent_valid[i] && ent_key[i] == key)
				return i;
		return -1;
	endfunction

	// bump the use count (saturating) and make the entry most recent
	function automatic void refresh_entry(int e);
		logic [RANK_W-1:0] r;
		r = ent_rank[e];
		for (int i = 0; i < CAP; i++)
			if (ent_valid[i] && ent_rank[i] < r)
				ent_rank[i]++;
		ent_rank[e] = '0;
		if (ent_count[e] != '1)
			ent_count[e]++;
		else
			saturated_touches++;
	endfunction

	function automatic out_item_t cache_access(in_item_t req);
		out_item_t         res;
		int                e;
		int                victim;
		int                eff_cap;
		logic [RANK_W-1:0] vr;
		res = '0;
		eff_cap = (cache_cap > CAP) ? CAP : int'(cache_cap);
		e = find_entry(req.lookup_key);
		if (req.action == ACT_GET) begin
			if (e >= 0) begin
				refresh_entry(e);
				res.hit = 1'b1;
				res.read_value = ent_value[e];
			end else begin
				res.read_value = MISS_VALUE;
			end
		end else if (eff_cap > 0) begin
			if (e >= 0) begin
				ent_value[e] = req.store_value;
				refresh_entry(e);
				res.hit = 1'b1;
			end else begin
				if (held >= eff_cap) begin
					// lowest count, oldest access among equal counts
					victim = -1;
					for (int i = 0; i < CAP; i++)
						if (ent_valid[i] && (victim < 0 || ent_count[i] < ent_count[victim] ||
						    (ent_count[i] == ent_count[victim] &&
						     ent_rank[i] > ent_rank[victim])))
							victim = i;
					if (victim >= 0) begin
						res.evicted = 1'b1;
						res.evicted_key = ent_key[victim];
						ent_valid[victim] = 1'b0;
						vr = ent_rank[victim];
						for (int i = 0; i < CAP; i++)
							if (ent_valid[i] && ent_rank[i] > vr)
								ent_rank[i]--;
						held--;
					end
				end
				e = -1;
				for (int i = 0; i < CAP; i++)
					if (!ent_valid[i] && e < 0)
						e = i;
				if (e >= 0) begin
					for (int i = 0; i < CAP; i++)
						if (ent_valid[i])
							ent_rank[i]++;
					ent_valid[e] = 1'b1;
					ent_key[e] = req.lookup_key;
					ent_value[e] = req.store_value;
					ent_count[e] = CNT_W'(1);
					ent_rank[e] = '0;
					held++;
				end
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input out_item_t want,
	                               input out_item_t got);
		errors++;
		if (errors <= 10)
			$display("%0t %s: want hit %0b rd %0d ev %0b evk %0d, got hit %0b rd %0d ev %0b evk %0d",
			         $realtime, what, want.hit, want.read_value, want.evicted, want.evicted_key,
			         got.hit, got.read_value, got.evicted, got.evicted_key);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (results_taken != items_sent || busy)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [CFG_W-1:0] cap);
		wait_drained();
		cfg_data <= cap;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cache_cap = cap;
		cfg_writes++;
	endtask

	task automatic issue(input in_item_t req, input logic typed, input out_item_t want,
	                     input bit burst);
		int        gap;
		out_item_t predicted;
		out_item_t expected;
		gap = burst ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request <= req;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		predicted = cache_access(req);
		expected = typed ? want : predicted;
		pending_results = {pending_results, expected};
		items_sent++;
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid) begin
			results_taken <= results_taken + 1;
			if (pending_results.size() == 0) begin
				report_mismatch("result with no pending transaction", '0, result);
			end else begin
				want = pending_results.pop_front();
				if (result.hit !== want.hit || result.read_value !== want.read_value ||
				    result.evicted !== want.evicted || result.evicted_key !== want.evicted_key)
					report_mismatch("result mismatch", want, result);
				if (want.hit)
					hits_seen++;
				else if (want.read_value == MISS_VALUE)
					misses_seen++;
				if (want.evicted)
					evictions_seen++;
			end
		end
	end

	// watchdog: cycles without any transaction on any port
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("timeout after %0d idle cycles, %0d results outstanding",
		         stall_cycles, pending_results.size());
		$display("tb_lfu_cache_lru_tiebreak NOT OK");
		$finish;
	end

	initial begin
		in_item_t req;
		bit       burst;
		items_sent = 0;
		results_taken = 0;
		errors = 0;
		cfg_writes = 0;
		hits_seen = 0;
		misses_seen = 0;
		evictions_seen = 0;
		saturated_touches = 0;
		stall_cycles = 0;
		held = 0;
		cache_cap = CAP_RESET;
		for (int i = 0; i < CAP; i++) begin
			ent_valid[i] = 1'b0;
			ent_key[i] = '0;
			ent_value[i] = '0;
			ent_count[i] = '0;
			ent_rank[i] = '0;
		end
		key_pool[0] = K_MIN;
		key_pool[1] = K_MAX;
		key_pool[2] = 32'sh0;
		key_pool[3] = K_NEG1;
		for (int i = 4; i < POOL_MAX; i++)
			key_pool[i] = $urandom;

		arst_n <= 1'b0;
		start <= 1'b0;
		request <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (PLAN[i].is_cfg)
				write_capacity(PLAN[i].cap);
			else
				issue(PLAN[i].req, PLAN[i].typed, PLAN[i].want, $urandom_range(0, 3) == 0);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_capacity(PHASES[p].cap);
			burst = 1'b0;
			for (int n = 0; n < PHASES[p].items; n++) begin
				// back-to-back stretches now and then
				if (n % 16 == 0)
					burst = ($urandom_range(0, 2) == 0);
				req.action = ($urandom_range(0, 1) == 1) ? ACT_PUT : ACT_GET;
				if ($urandom_range(0, 99) < 80)
					req.lookup_key = key_pool[$urandom_range(0, PHASES[p].pool - 1)];
				else
					req.lookup_key = $urandom;
				req.store_value = $urandom;
				issue(req, 1'b0, '0, burst);
			end
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("transaction never answered", pending_results[0], '0);

		$display("%0d transactions over %0d capacity writes (0 to 31, clamped above %0d)",
		         items_sent, cfg_writes, CAP);
		$display("%0d hits, %0d get misses, %0d evictions, %0d accesses at saturated count",
		         hits_seen, misses_seen, evictions_seen, saturated_touches);
		if (errors == 0)
			$display("tb_lfu_cache_lru_tiebreak OK");
		else
			$display("tb_lfu_cache_lru_tiebreak NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/lfuc_pkg.sv
sv/lfuc_ram.sv
sv/lfu_cache_lru_tiebreak.sv
verif/tb_lfu_cache_lru_tiebreak.sv
